>>> hdl/aphb_pkg.sv
// Package for the audio preroll history buffer.
// Holds sizes, the operation code and the per-item result record.
// No dependencies; used by aphb_ctrl and the top level.
package aphb_pkg;

  // Ring storage depth in bytes. The count and size fields are 13 bits wide,
  // so the depth stays at or below 8191.
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIZE_W = 13;
  localparam int POS_W  = 64;
  localparam int BYTE_W = 8;

  localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(DEPTH);

  // Operation carried in s_axis_tuser
  typedef enum logic {
    OP_READ   = 1'b0,
    OP_REWIND = 1'b1
  } op_t;

  // Result of one item as decided at accept time; the history byte itself
  // arrives from the registered read of the ring memory in the next cycle.
  typedef struct packed {
    logic              hist;
    logic [BYTE_W-1:0] live_byte;
    logic [SIZE_W-1:0] count;
  } aphb_res_t;

endpackage

>>> hdl/aphb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module aphb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/aphb_ctrl.sv
// Ring control for the audio preroll history buffer: positions, head, fill,
// size register and the read/write addresses of the ring memory.
// Depends on aphb_pkg.
module aphb_ctrl import aphb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,          // item accepted this cycle
  input  op_t                      op,
  input  logic [BYTE_W-1:0]        src,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_wdata,
  output logic                     ram_we,
  output logic [ADDR_W-1:0]        ram_waddr,
  output logic [BYTE_W-1:0]        ram_wdata,
  output logic                     ram_re,
  output logic [ADDR_W-1:0]        ram_raddr,
  output aphb_res_t                res
);

  // state registers
  logic [POS_W-1:0]  oldest;
  logic [POS_W-1:0]  end_pos;   // oldest + fill, modulo 2^64
  logic [POS_W-1:0]  reader;
  logic [SIZE_W-1:0] fill;
  logic [ADDR_W-1:0] head;
  logic [SIZE_W-1:0] size;

  logic [POS_W-1:0]  oldest_next;
  logic [POS_W-1:0]  end_pos_next;
  logic [POS_W-1:0]  reader_next;
  logic [SIZE_W-1:0] fill_next;
  logic [ADDR_W-1:0] head_next;
  logic [SIZE_W-1:0] size_next;

  logic              lag;
  logic              live;
  logic              full;
  logic [POS_W-1:0]  rd_clamped;
  logic [SIZE_W-1:0] head_plus;
  logic [ADDR_W-1:0] head_inc;
  logic [SIZE_W:0]   tail_sum;
  logic [SIZE_W:0]   tail_mod;
  logic [ADDR_W-1:0] tail;
  logic [SIZE_W-1:0] cfg_size;

  // reader clamp and live/history decision
  always_comb begin
    lag        = reader < oldest;
    rd_clamped = lag ? oldest : reader;
    live       = lag ? (oldest >= end_pos) : (reader >= end_pos);
    full       = fill >= size;
  end

  // ring index arithmetic: head + 1 and head + fill, both modulo size
  always_comb begin
    head_plus = SIZE_W'(head) + SIZE_W'(1);
    head_inc  = (head_plus >= size) ? '0 : head_plus[ADDR_W-1:0];
    tail_sum  = (SIZE_W+1)'(head) + (SIZE_W+1)'(fill);
    tail_mod  = (tail_sum >= (SIZE_W+1)'(size)) ? tail_sum - (SIZE_W+1)'(size) : tail_sum;
    tail      = tail_mod[ADDR_W-1:0];
  end

  // clamp of a written size to 1..DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (cfg_wdata > DEPTH_SZ) begin
      cfg_size = DEPTH_SZ;
    end else begin
      cfg_size = cfg_wdata;
    end
  end

  // next state, memory access and result of the item
  always_comb begin
    oldest_next  = oldest;
    end_pos_next = end_pos;
    reader_next  = reader;
    fill_next    = fill;
    head_next    = head;
    size_next    = size;
    ram_we       = 1'b0;
    ram_waddr    = tail;
    ram_wdata    = src;
    ram_re       = 1'b0;
    ram_raddr    = head;
    res.hist      = 1'b0;
    res.live_byte = '0;
    if (go) begin
      if (op == OP_REWIND) begin
        reader_next = '0;
      end else begin
        reader_next = rd_clamped + POS_W'(1);
        if (live) begin
          // live byte goes out and into the ring
          res.live_byte = src;
          ram_we        = 1'b1;
          end_pos_next  = end_pos + POS_W'(1);
          if (full) begin
            // overwrite the oldest byte in place
            ram_waddr   = head;
            head_next   = head_inc;
            oldest_next = oldest + POS_W'(1);
          end else begin
            fill_next = fill + SIZE_W'(1);
          end
        end else begin
          // oldest stored byte goes out and leaves the ring
          res.hist    = 1'b1;
          ram_re      = 1'b1;
          head_next   = head_inc;
          fill_next   = fill - SIZE_W'(1);
          oldest_next = oldest + POS_W'(1);
        end
      end
    end else if (cfg_we) begin
      // new size empties the ring; dropped bytes count as consumed
      size_next   = cfg_size;
      oldest_next = end_pos;
      fill_next   = '0;
      head_next   = '0;
    end
    res.count = fill_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest  <= '0;
      end_pos <= '0;
      reader  <= '0;
      fill    <= '0;
      head    <= '0;
      size    <= DEPTH_SZ;
    end else begin
      oldest  <= oldest_next;
      end_pos <= end_pos_next;
      reader  <= reader_next;
      fill    <= fill_next;
      head    <= head_next;
      size    <= size_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_le_size: assert property (@(posedge clk) disable iff (rst)
    fill <= size) else $error("fill above ring size");

  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    SIZE_W'(head) < size) else $error("head outside ring");

  a_end_tracks: assert property (@(posedge clk) disable iff (rst)
    end_pos == oldest + POS_W'(fill)) else $error("end position out of step");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re)) else $error("read and write in one item");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && !go) |=> (fill == '0 && head == '0)) else $error("size write kept data");
`endif

endmodule

>>> hdl/audio_preroll_history_buffer.sv
// Audio preroll history buffer, top level.
// Depends on aphb_pkg, aphb_ctrl and aphb_ram.
//
// The block takes one item per clock unless stage 1 is full and the output is
// stalled, and gives one result per item. All ring bookkeeping (positions,
// head, fill) sits in registers that update at the accept edge, so a byte
// written by one item is readable by the next with no forwarding; the ring bytes
// live in one RAM with a write port and a registered read port. The RAM read and
// stage 1 load at the accept edge; the output register loads from stage 1 when
// the output is free. s_axis_tready follows m_axis_tready combinationally when
// both stages are full. The RAM needs no clearing pass after reset: no ring
// entry is read before it is written. The user must write history_size only
// while no item is in flight; the block itself does not enforce this.
module audio_preroll_history_buffer import aphb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] source_byte
  input  logic              s_axis_tuser,   // [0] operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [7:0] data_byte, [20:8] buffered_count
  output logic              m_axis_tuser,   // [0] from_history
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata       // history_size
);

  logic              accept;
  logic              out_free;
  logic              s1_move;
  logic              s1_valid;
  aphb_res_t         s1_res;
  aphb_res_t         res;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] s1_byte;

  // handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_move       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  aphb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .go        (accept),
    .op        (op_t'(s_axis_tuser)),
    .src       (s_axis_tdata[BYTE_W-1:0]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  aphb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stage 1: waits for the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
  end

  assign s1_byte = s1_res.hist ? ram_rdata : s1_res.live_byte;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tdata <= {3'b000, s1_res.count, s1_byte};
      m_axis_tuser <= s1_res.hist;
    end
  end

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |-> !s_axis_tready) else $error("accept into full stage");

  a_s1_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid) else $error("accepted item lost");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> m_axis_tvalid) else $error("result not presented");
`endif

endmodule
